### design/iir_pkg.sv
`timescale 1ns / 1ps

package iir_pkg;

  // filter order and coefficient fraction bits
  localparam int ORDER     = 4;
  localparam int COEF_FRAC = 44;

  // coefficient store holds a1..aN then b0..bN
  localparam int NCOEF = 2 * ORDER + 1;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 48;
  localparam int IDX_W    = 4;
  localparam int TAP_W    = 64;
  localparam int OUT_W    = 32;
  localparam int ACC_W    = 128;

  // operand split for the shared multiplier
  localparam int CLO_W   = 24;
  localparam int TLO_W   = 32;
  localparam int CPC_W   = CLO_W + 1;
  localparam int TPC_W   = TLO_W + 1;
  localparam int PROD_W  = CPC_W + TPC_W;

  // sample lands at 16 + COEF_FRAC fraction bits
  localparam int SMP_SH = 16 + COEF_FRAC;

  // index widths
  localparam int CIW    = $clog2(NCOEF);
  localparam int KW     = $clog2(ORDER + 1);
  localparam int TAP_IW = (ORDER > 1) ? $clog2(ORDER) : 1;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // accumulator operations issued by the sequencer
  typedef enum logic [1:0] {
    MAC_NOP,
    MAC_LOAD_SAMPLE,
    MAC_LOAD_ZERO,
    MAC_ROUND
  } mac_op_t;

  // control from sequencer to the multiply-accumulate unit
  typedef struct packed {
    mac_op_t                     op;
    logic                        mul_en;
    logic                        sub;
    logic [1:0]                  part;
    logic signed [SAMPLE_W-1:0]  sample;
  } mac_ctl_t;

  // reduced accumulator value back to the sequencer
  typedef struct packed {
    logic signed [TAP_W-1:0] value;
    logic                    ovf;
  } mac_stat_t;

endpackage

### design/iir_if.sv
`timescale 1ns / 1ps

// input item channel
interface iir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [iir_pkg::SAMPLE_W-1:0] sample_in;
  logic [iir_pkg::IDX_W-1:0]           coef_index;
  logic signed [iir_pkg::COEF_W-1:0]   coef_value;

  modport source (output valid, command, sample_in, coef_index, coef_value, input ready);
  modport sink (input valid, command, sample_in, coef_index, coef_value, output ready);
endinterface

// result item channel
interface iir_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [iir_pkg::OUT_W-1:0] sample_out;
  logic                             is_sample;
  logic                             saturated;

  modport source (output valid, sample_out, is_sample, saturated, input ready);
  modport sink (input valid, sample_out, is_sample, saturated, output ready);
endinterface

### design/iir_direct_form_two_filter.sv
`timescale 1ns / 1ps

// direct form II iir filter, one shared multiply-accumulate unit
// in_ch carries items: command 0 filters sample_in, command 1 writes
// coef_value into coefficient coef_index (a1..aN, then b0..bN)
// out_ch gives one item per input item: the Q16.16 sample with is_sample
// high and saturated flagging a clip, or an all-zero write acknowledge
// a sample runs from acceptance through the a-taps, w0 and the b-taps
// to S_Y, which loads out_ch and returns to idle for the next item; the
// 25x33 multiplier forms four partial products per tap, one per cycle,
// over ORDER a-taps and ORDER+1 b-taps, plus drain, round and capture
// a write is acknowledged from S_ACK once the output register is free
// in_ch.ready is high only while the sequencer is idle
// results sit in an output register; if the receiver stalls, the block
// finishes the next item and then holds until the register is taken
// reset clears the delay line, the coefficients and any pending result

module iir_direct_form_two_filter (
  input  logic      clk,
  input  logic      rst_n,
  iir_in_if.sink    in_ch,
  iir_out_if.source out_ch
);

  localparam int ORDER  = iir_pkg::ORDER;
  localparam int KW     = iir_pkg::KW;
  localparam int CIW    = iir_pkg::CIW;
  localparam int TAP_W  = iir_pkg::TAP_W;
  localparam int OUT_W  = iir_pkg::OUT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK,
    S_MUL_A,
    S_DRAIN_A,
    S_ROUND_A,
    S_W0,
    S_MUL_B,
    S_DRAIN_B,
    S_ROUND_B,
    S_Y
  } state_t;

  state_t                    state_r, state_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [1:0]                p_r, p_nxt;
  logic signed [TAP_W-1:0]   w0_r, w0_nxt;
  logic                      sat_r, sat_nxt;
  logic signed [TAP_W-1:0]   dly_r [ORDER];
  logic signed [TAP_W-1:0]   dly_nxt [ORDER];
  logic                      out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]   out_sample_r, out_sample_nxt;
  logic                      out_is_r, out_is_nxt;
  logic                      out_sat_r, out_sat_nxt;

  iir_pkg::mac_ctl_t          ctl;
  iir_pkg::mac_stat_t         stat;
  logic signed [iir_pkg::COEF_W-1:0] coef;
  logic signed [TAP_W-1:0]    tap;
  logic [CIW-1:0]             raddr;
  logic                       in_acc;
  logic                       coef_we;
  logic                       slot_free;
  logic                       y_fits;
  logic [TAP_W-OUT_W:0]       y_top;
  logic [KW-1:0]              k_dec;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign k_dec       = k_r - KW'(1);

  // output saturation check on the reduced value
  assign y_top  = stat.value[TAP_W-1:OUT_W-1];
  assign y_fits = (&y_top) | ~(|y_top);

  iir_coef_store u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (coef_we),
    .waddr (in_ch.coef_index),
    .wdata (in_ch.coef_value),
    .raddr (raddr),
    .rdata (coef)
  );

  iir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef),
    .tap   (tap),
    .stat  (stat)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    p_nxt          = p_r;
    w0_nxt         = w0_r;
    sat_nxt        = sat_r;
    dly_nxt        = dly_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_is_nxt     = out_is_r;
    out_sat_nxt    = out_sat_r;
    coef_we        = 1'b0;
    raddr          = CIW'(k_r);
    tap            = dly_r[k_r[iir_pkg::TAP_IW-1:0]];
    ctl.op         = iir_pkg::MAC_NOP;
    ctl.mul_en     = 1'b0;
    ctl.sub        = 1'b0;
    ctl.part       = p_r;
    ctl.sample     = in_ch.sample_in;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == iir_pkg::CMD_WRITE) begin
            coef_we   = 1'b1;
            state_nxt = S_ACK;
          end else begin
            ctl.op    = iir_pkg::MAC_LOAD_SAMPLE;
            k_nxt     = '0;
            p_nxt     = '0;
            sat_nxt   = 1'b0;
            state_nxt = S_MUL_A;
          end
        end
      end
      S_ACK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = '0;
          out_is_nxt     = 1'b0;
          out_sat_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      // feedback taps: subtract a_i * d_i
      S_MUL_A: begin
        ctl.mul_en = 1'b1;
        ctl.sub    = 1'b1;
        p_nxt      = p_r + 2'd1;
        if (p_r == 2'd3) begin
          k_nxt = k_r + KW'(1);
          if (k_r == KW'(ORDER - 1)) begin
            state_nxt = S_DRAIN_A;
          end
        end
      end
      S_DRAIN_A: begin
        state_nxt = S_ROUND_A;
      end
      S_ROUND_A: begin
        ctl.op    = iir_pkg::MAC_ROUND;
        state_nxt = S_W0;
      end
      S_W0: begin
        w0_nxt    = stat.value;
        sat_nxt   = sat_r | stat.ovf;
        ctl.op    = iir_pkg::MAC_LOAD_ZERO;
        k_nxt     = '0;
        p_nxt     = '0;
        state_nxt = S_MUL_B;
      end
      // feedforward taps: b0 * w0, then b_i * d_i
      S_MUL_B: begin
        ctl.mul_en = 1'b1;
        raddr      = CIW'(ORDER) + CIW'(k_r);
        if (k_r == '0) begin
          tap = w0_r;
        end else begin
          tap = dly_r[k_dec[iir_pkg::TAP_IW-1:0]];
        end
        p_nxt = p_r + 2'd1;
        if (p_r == 2'd3) begin
          k_nxt = k_r + KW'(1);
          if (k_r == KW'(ORDER)) begin
            state_nxt = S_DRAIN_B;
          end
        end
      end
      S_DRAIN_B: begin
        state_nxt = S_ROUND_B;
      end
      S_ROUND_B: begin
        ctl.op    = iir_pkg::MAC_ROUND;
        state_nxt = S_Y;
      end
      S_Y: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_is_nxt    = 1'b1;
          out_sat_nxt   = sat_r | stat.ovf | !y_fits;
          if (y_fits) begin
            out_sample_nxt = stat.value[OUT_W-1:0];
          end else if (stat.value[TAP_W-1]) begin
            out_sample_nxt = {1'b1, {(OUT_W-1){1'b0}}};
          end else begin
            out_sample_nxt = {1'b0, {(OUT_W-1){1'b1}}};
          end
          // shift the delay line, w0 enters at the front
          for (int i = ORDER - 1; i > 0; i--) begin
            dly_nxt[i] = dly_r[i-1];
          end
          dly_nxt[0] = w0_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, delay line and output register
  always_ff @(posedge clk) begin
    w0_r         <= w0_nxt;
    out_sample_r <= out_sample_nxt;
    out_is_r     <= out_is_nxt;
    out_sat_r    <= out_sat_nxt;
    k_r          <= k_nxt;
    p_r          <= p_nxt;
    sat_r        <= sat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dly_r       <= dly_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.is_sample  = out_is_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

### design/iir_coef_store.sv
`timescale 1ns / 1ps

module iir_coef_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we,
  input  logic [iir_pkg::IDX_W-1:0]         waddr,
  input  logic signed [iir_pkg::COEF_W-1:0] wdata,
  input  logic [iir_pkg::CIW-1:0]           raddr,
  output logic signed [iir_pkg::COEF_W-1:0] rdata
);

  logic signed [iir_pkg::COEF_W-1:0] coef_r [iir_pkg::NCOEF];

  // writes beyond the last coefficient are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iir_pkg::NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (we && (int'(waddr) < iir_pkg::NCOEF)) begin
      coef_r[iir_pkg::CIW'(waddr)] <= wdata;
    end
  end

  assign rdata = coef_r[raddr];

endmodule

### design/iir_mac.sv
`timescale 1ns / 1ps

module iir_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iir_pkg::mac_ctl_t                 ctl,
  input  logic signed [iir_pkg::COEF_W-1:0] coef,
  input  logic signed [iir_pkg::TAP_W-1:0]  tap,
  output iir_pkg::mac_stat_t                stat
);

  localparam int ACC_W = iir_pkg::ACC_W;
  localparam int HI_W  = ACC_W - iir_pkg::COEF_FRAC - iir_pkg::TAP_W + 1;

  logic signed [iir_pkg::CPC_W-1:0]  cpc;
  logic signed [iir_pkg::TPC_W-1:0]  tpc;
  logic signed [iir_pkg::PROD_W-1:0] prod_r;
  logic                              acc_en_r;
  logic                              sub_r;
  logic [1:0]                        part_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_nxt;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           addend;
  logic signed [ACC_W-1:0]           shifted;
  logic [HI_W-1:0]                   top_bits;
  logic                              fits;

  // operand pieces: low halves unsigned, high halves signed
  always_comb begin
    if (ctl.part[0]) begin
      cpc = $signed({coef[iir_pkg::COEF_W-1], coef[iir_pkg::COEF_W-1:iir_pkg::CLO_W]});
    end else begin
      cpc = $signed({1'b0, coef[iir_pkg::CLO_W-1:0]});
    end
    if (ctl.part[1]) begin
      tpc = $signed({tap[iir_pkg::TAP_W-1], tap[iir_pkg::TAP_W-1:iir_pkg::TLO_W]});
    end else begin
      tpc = $signed({1'b0, tap[iir_pkg::TLO_W-1:0]});
    end
  end

  // partial product register
  always_ff @(posedge clk) begin
    prod_r <= cpc * tpc;
    sub_r  <= ctl.sub;
    part_r <= ctl.part;
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= ctl.mul_en;
    end
  end

  // align the partial product to its weight
  assign prod_ext = ACC_W'(prod_r);
  always_comb begin
    case (part_r)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext <<< iir_pkg::CLO_W;
      2'd2:    addend = prod_ext <<< iir_pkg::TLO_W;
      default: addend = prod_ext <<< (iir_pkg::CLO_W + iir_pkg::TLO_W);
    endcase
  end

  // accumulator update
  always_comb begin
    acc_nxt = acc_r;
    if (acc_en_r) begin
      acc_nxt = sub_r ? (acc_r - addend) : (acc_r + addend);
    end else begin
      case (ctl.op)
        iir_pkg::MAC_LOAD_SAMPLE: acc_nxt = ACC_W'(ctl.sample) <<< iir_pkg::SMP_SH;
        iir_pkg::MAC_LOAD_ZERO:   acc_nxt = '0;
        iir_pkg::MAC_ROUND:       acc_nxt = acc_r + (ACC_W'(1) <<< (iir_pkg::COEF_FRAC - 1));
        default:                  acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // drop fraction bits and saturate to the tap width
  assign shifted  = acc_r >>> iir_pkg::COEF_FRAC;
  assign top_bits = shifted[ACC_W-iir_pkg::COEF_FRAC-1:iir_pkg::TAP_W-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    stat.ovf = ~fits;
    if (fits) begin
      stat.value = shifted[iir_pkg::TAP_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      stat.value = {1'b1, {(iir_pkg::TAP_W-1){1'b0}}};
    end else begin
      stat.value = {1'b0, {(iir_pkg::TAP_W-1){1'b1}}};
    end
  end

endmodule
